### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms, reset disables checking
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// shared types and constants of the i2c master bit sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

   // bus commands, anything else is no command
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_WAIT  = 3'd5
   } cmd_type;

   // classified request held in the queue
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] write_data;
      logic       send_ack;
      logic       sda_in;
   } item_type;

   localparam int QueueDepth = 2;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);

   localparam int PhaseWidth = 5;
   localparam int DataWidth  = 8;

   // register map
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam logic REG_ACK_TIMEOUT = 1'b0;  // selected by paddr[2]
   localparam logic [DataWidth-1:0] TimeoutReset = 8'd100;

endpackage

### sv/i2cms_front.sv
// ----------------------------------------------------------------------------
// i2cms_front
// accepts requests, classifies the command and queues them for the sequencer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cms_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_cmd,
   input  logic [7:0]           req_write_data,
   input  logic                 req_send_ack,
   input  logic                 req_sda_in,
   output i2cms_pkg::item_type  q_item,
   output logic                 q_valid,
   input  logic                 q_pop
);

   i2cms_pkg::item_type                          queue_ff [i2cms_pkg::QueueDepth];
   logic [i2cms_pkg::PtrWidth-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [i2cms_pkg::PtrWidth-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [i2cms_pkg::CountWidth-1:0]             count_ff, count_in;
   i2cms_pkg::cmd_type                           cmd_class;
   i2cms_pkg::item_type                          push_item;
   logic                                         push;

   // undefined codes are treated as no command
   always_comb begin
      unique case (req_cmd) inside
         i2cms_pkg::CMD_START, i2cms_pkg::CMD_STOP, i2cms_pkg::CMD_WRITE,
         i2cms_pkg::CMD_READ, i2cms_pkg::CMD_WAIT: cmd_class = i2cms_pkg::cmd_type'(req_cmd);
         default: cmd_class = i2cms_pkg::CMD_NONE;
      endcase
   end

   assign push_item = '{cmd: cmd_class, write_data: req_write_data,
                        send_ack: req_send_ack, sda_in: req_sda_in};

   assign req_stall = (count_ff == i2cms_pkg::CountWidth'(i2cms_pkg::QueueDepth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + i2cms_pkg::PtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + i2cms_pkg::PtrWidth'(1) : rd_ptr_ff;
      case ({push, q_pop})
         2'b10:   count_in = count_ff + i2cms_pkg::CountWidth'(1);
         2'b01:   count_in = count_ff - i2cms_pkg::CountWidth'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ASSERT_ALWAYS(a_count_in_range, clock, reset,
      count_ff <= i2cms_pkg::CountWidth'(i2cms_pkg::QueueDepth))
   `ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, q_pop, count_ff != '0)

endmodule

### sv/i2cms_back.sv
// ----------------------------------------------------------------------------
// i2cms_back
// bus phase sequencer, one queued request per cycle into the result register unless stalled
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cms_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [i2cms_pkg::DataWidth-1:0]     ack_timeout,
   input  i2cms_pkg::item_type                 q_item,
   input  logic                                q_valid,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_scl,
   output logic                                rsp_sda_drive,
   output logic                                rsp_busy_res,
   output logic [7:0]                          rsp_read_data,
   output logic                                rsp_ack_error,
   output logic                                rsp_done_res
);

   localparam int BitPhases = 2 * i2cms_pkg::DataWidth;

   // sequencer state
   i2cms_pkg::cmd_type                   active_ff, active_in;
   logic [i2cms_pkg::PhaseWidth-1:0]     phase_ff, phase_in;
   logic [i2cms_pkg::DataWidth-1:0]      shift_ff, shift_in;
   logic [i2cms_pkg::DataWidth-1:0]      poll_ff, poll_in;
   logic                                 ack_choice_ff, ack_choice_in;
   logic                                 scl_lvl_ff, scl_lvl_in;
   logic                                 sda_lvl_ff, sda_lvl_in;
   logic [i2cms_pkg::DataWidth-1:0]      last_read_ff, last_read_in;

   // result register
   logic                                 rsp_valid_ff;
   logic                                 scl_ff, sda_ff, busy_ff, err_ff, done_ff;
   logic [i2cms_pkg::DataWidth-1:0]      read_ff;

   logic                                 starting;
   i2cms_pkg::cmd_type                   act;
   logic [i2cms_pkg::PhaseWidth-1:0]     p;
   logic [i2cms_pkg::PhaseWidth-1:0]     phase_step;
   logic                                 done_c, err_c;
   logic [2:0]                           bit_sel;

   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   assign bit_sel = 3'd7 - p[3:1];

   always_comb begin
      starting = (active_ff == i2cms_pkg::CMD_NONE) && (q_item.cmd != i2cms_pkg::CMD_NONE);
      act      = starting ? q_item.cmd : active_ff;
      p        = starting ? '0 : phase_ff;
      poll_in  = starting ? '0 : poll_ff;
      shift_in = shift_ff;
      if (starting) begin
         shift_in = (q_item.cmd == i2cms_pkg::CMD_WRITE) ? q_item.write_data : '0;
      end
      ack_choice_in = (starting && q_item.cmd == i2cms_pkg::CMD_READ) ? q_item.send_ack
                                                                       : ack_choice_ff;
      scl_lvl_in   = scl_lvl_ff;
      sda_lvl_in   = sda_lvl_ff;
      last_read_in = last_read_ff;
      phase_step   = p + i2cms_pkg::PhaseWidth'(1);
      done_c       = 1'b0;
      err_c        = 1'b0;

      unique case (act)
         i2cms_pkg::CMD_START: begin
            scl_lvl_in = (p < 5'd2);
            sda_lvl_in = (p == 5'd0);
            done_c     = (p >= 5'd2);
         end
         i2cms_pkg::CMD_STOP: begin
            scl_lvl_in = (p != 5'd0);
            sda_lvl_in = (p >= 5'd2);
            done_c     = (p >= 5'd2);
         end
         i2cms_pkg::CMD_WRITE: begin
            if (p < i2cms_pkg::PhaseWidth'(BitPhases)) begin
               sda_lvl_in = shift_in[bit_sel];
               scl_lvl_in = p[0];
            end else begin
               sda_lvl_in = shift_in[0];
               scl_lvl_in = 1'b0;
               done_c     = 1'b1;
            end
         end
         i2cms_pkg::CMD_READ: begin
            if (p < i2cms_pkg::PhaseWidth'(BitPhases)) begin
               scl_lvl_in = p[0];
               sda_lvl_in = 1'b1;
               // sample on the high half
               if (p[0]) begin
                  shift_in = {shift_in[i2cms_pkg::DataWidth-2:0], q_item.sda_in};
               end
            end else begin
               sda_lvl_in = !ack_choice_in;
               scl_lvl_in = (p == 5'd17);
               if (p >= 5'd18) begin
                  done_c       = 1'b1;
                  last_read_in = shift_in;
               end
            end
         end
         i2cms_pkg::CMD_WAIT: begin
            if (p == 5'd0) begin
               scl_lvl_in = 1'b1;
               sda_lvl_in = 1'b1;
            end else if (p == 5'd1) begin
               if (!q_item.sda_in) begin
                  scl_lvl_in = 1'b0;
                  sda_lvl_in = 1'b1;
                  done_c     = 1'b1;
               end else if (poll_in >= ack_timeout) begin
                  // give up, run the stop tail
                  scl_lvl_in = 1'b0;
                  sda_lvl_in = 1'b0;
                  phase_step = 5'd3;
               end else begin
                  poll_in    = poll_in + i2cms_pkg::DataWidth'(1);
                  scl_lvl_in = 1'b1;
                  sda_lvl_in = 1'b1;
                  phase_step = 5'd1;
               end
            end else if (p == 5'd3) begin
               scl_lvl_in = 1'b1;
               sda_lvl_in = 1'b0;
            end else begin
               scl_lvl_in = 1'b1;
               sda_lvl_in = 1'b1;
               done_c     = 1'b1;
               err_c      = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (act == i2cms_pkg::CMD_NONE) begin
         active_in = i2cms_pkg::CMD_NONE;
         phase_in  = phase_ff;
      end else if (done_c) begin
         active_in = i2cms_pkg::CMD_NONE;
         phase_in  = '0;
      end else begin
         active_in = act;
         phase_in  = phase_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= i2cms_pkg::CMD_NONE;
         phase_ff      <= '0;
         shift_ff      <= '0;
         poll_ff       <= '0;
         ack_choice_ff <= 1'b0;
         scl_lvl_ff    <= 1'b1;
         sda_lvl_ff    <= 1'b1;
         last_read_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (q_pop) begin
            active_ff     <= active_in;
            phase_ff      <= phase_in;
            shift_ff      <= shift_in;
            poll_ff       <= poll_in;
            ack_choice_ff <= ack_choice_in;
            scl_lvl_ff    <= scl_lvl_in;
            sda_lvl_ff    <= sda_lvl_in;
            last_read_ff  <= last_read_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         scl_ff  <= scl_lvl_in;
         sda_ff  <= sda_lvl_in;
         busy_ff <= (active_in != i2cms_pkg::CMD_NONE);
         read_ff <= last_read_in;
         err_ff  <= err_c;
         done_ff <= done_c;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl       = scl_ff;
   assign rsp_sda_drive = sda_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_read_data = read_ff;
   assign rsp_ack_error = err_ff;
   assign rsp_done_res  = done_ff;

   `ASSERT_NEXT(a_done_goes_idle, clock, reset, q_pop && done_c,
      active_ff == i2cms_pkg::CMD_NONE && rsp_valid_ff)
   `ASSERT_IMPLIES(a_error_only_when_done, clock, reset, q_pop && err_c, done_c)
   `ASSERT_IMPLIES(a_byte_phase_bound, clock, reset,
      active_ff == i2cms_pkg::CMD_WRITE || active_ff == i2cms_pkg::CMD_READ,
      phase_ff <= 5'd18)

endmodule

### sv/i2c_master_bit_sequencer_top.sv
// path: an accepted request is queued in the front, then popped into the result register
// throughput: one request per cycle when not stalled, each request is one bus half-bit tick
// the two-entry queue between front and sequencer absorbs rsp stall until full, then req_stall rises
// reset: synchronous, active high; sequencer idle, its scl/sda levels high,
// ack_timeout back to 100, queue and result register empty
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top
// i2c master bit sequencer: per-tick scl/sda drive with start, stop, byte
// write, byte read with ack/nack and ack wait with timeout
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel, one bus tick per request
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [2:0]                            req_cmd,
   input  logic [7:0]                            req_write_data,
   input  logic                                  req_send_ack,
   input  logic                                  req_sda_in,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_scl,
   output logic                                  rsp_sda_drive,
   output logic                                  rsp_busy_res,
   output logic [7:0]                            rsp_read_data,
   output logic                                  rsp_ack_error,
   output logic                                  rsp_done_res,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [i2cms_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [i2cms_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [i2cms_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   logic [i2cms_pkg::DataWidth-1:0]  ack_timeout_ff, ack_timeout_in;
   logic                             csr_write;
   logic                             csr_hit;
   i2cms_pkg::item_type              q_item;
   logic                             q_valid;
   logic                             q_pop;

   // register access, no wait states
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == i2cms_pkg::REG_ACK_TIMEOUT);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;

   assign ack_timeout_in = csr_write ? csr_pwdata[i2cms_pkg::DataWidth-1:0] : ack_timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff <= i2cms_pkg::TimeoutReset;
      end else begin
         ack_timeout_ff <= ack_timeout_in;
      end
   end

   // addresses past the map read as zero
   assign csr_prdata = csr_hit
      ? {{(i2cms_pkg::CsrDataWidth - i2cms_pkg::DataWidth){1'b0}}, ack_timeout_ff}
      : '0;

   // front: take requests, fold undefined codes into no command, queue them
   i2cms_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_write_data (req_write_data),
      .req_send_ack   (req_send_ack),
      .req_sda_in     (req_sda_in),
      .q_item         (q_item),
      .q_valid        (q_valid),
      .q_pop          (q_pop)
   );

   // back: phase sequencer, pops one queued request whenever the result
   // register is free or being drained
   i2cms_back u_back (
      .clock          (clock),
      .reset          (reset),
      .ack_timeout    (ack_timeout_ff),
      .q_item         (q_item),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl        (rsp_scl),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_read_data  (rsp_read_data),
      .rsp_ack_error  (rsp_ack_error),
      .rsp_done_res   (rsp_done_res)
   );

endmodule
